/* hdl/jts_pkg.sv */
`timescale 1ns / 1ps

package jts_pkg;

	// Default nesting limit and width of the indentation space count
	localparam int MAX_DEPTH_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int SP_W = 6;

	// Token function codes
	localparam logic [3:0] FN_OPEN_OBJ  = 4'd0;
	localparam logic [3:0] FN_CLOSE_OBJ = 4'd1;
	localparam logic [3:0] FN_OPEN_ARR  = 4'd2;
	localparam logic [3:0] FN_CLOSE_ARR = 4'd3;
	localparam logic [3:0] FN_OPEN_STR  = 4'd4;
	localparam logic [3:0] FN_STR_BYTE  = 4'd5;
	localparam logic [3:0] FN_CLOSE_STR = 4'd6;
	localparam logic [3:0] FN_RAW_START = 4'd7;
	localparam logic [3:0] FN_RAW_BYTE  = 4'd8;
	localparam logic [3:0] FN_BOOL      = 4'd9;

	// Value types
	localparam logic [2:0] VT_BOOL   = 3'd1;
	localparam logic [2:0] VT_STRING = 3'd3;
	localparam logic [2:0] VT_ARRAY  = 3'd4;
	localparam logic [2:0] VT_OBJECT = 3'd5;

	// Error codes
	localparam logic [2:0] ERR_OK           = 3'd0;
	localparam logic [2:0] ERR_CLOSE_ROOT   = 3'd1;
	localparam logic [2:0] ERR_KIND         = 3'd2;
	localparam logic [2:0] ERR_KEY_NO_VALUE = 3'd3;
	localparam logic [2:0] ERR_KEY_NOT_STR  = 3'd4;
	localparam logic [2:0] ERR_SECOND_ROOT  = 3'd5;
	localparam logic [2:0] ERR_TOO_DEEP     = 3'd6;

	// Body kinds of a queued command
	localparam logic [2:0] BK_NONE  = 3'd0;
	localparam logic [2:0] BK_CHAR  = 3'd1;
	localparam logic [2:0] BK_ESC   = 3'd2;
	localparam logic [2:0] BK_TRUE  = 3'd3;
	localparam logic [2:0] BK_FALSE = 3'd4;

	// Register indexes on the config port
	localparam logic REG_PRETTY = 1'b0;
	localparam logic REG_INDENT = 1'b1;

	// Characters
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	// One command from the front to the back
	typedef struct packed {
		logic [2:0]      err;
		logic            pre;
		logic            colon;
		logic            nl;
		logic [SP_W-1:0] sp;
		logic [2:0]      kind;
		logic [7:0]      data;
	} cmd_t;

endpackage

/* hdl/jts_if.sv */
`timescale 1ns / 1ps

// Token channel
interface jts_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] func;
	logic [7:0] in_byte;
	logic [2:0] value_type;

	modport source(output valid, output func, output in_byte, output value_type, input ready);
	modport sink(input valid, input func, input in_byte, input value_type, output ready);
endinterface

// Character channel
interface jts_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last;
	logic [2:0] error_code;

	modport source(output valid, output out_byte, output byte_valid, output last,
		output error_code, input ready);
	modport sink(input valid, input out_byte, input byte_valid, input last,
		input error_code, output ready);
endinterface

/* hdl/jts_front.sv */
`timescale 1ns / 1ps

module jts_front #(
	parameter int MAX_DEPTH = jts_pkg::MAX_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pretty,
	input  logic [2:0]     indent,
	jts_in_if.sink         tokens,
	output jts_pkg::cmd_t  cmd,
	output logic           cmd_valid,
	input  logic           cmd_ready
);

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	logic [MAX_DEPTH-1:0] arr_q, has_q, odd_q;
	logic [MAX_DEPTH-1:0] arr_d, has_d, odd_d;
	logic [DEPTH_W-1:0]   depth_q, depth_d;
	logic                 root_q, root_d;

	logic [IDX_W-1:0]     top_idx, push_idx;
	logic                 top_arr, top_has, top_odd;
	logic [2:0]           ind, vt, pre_err;
	logic                 accept;

	assign tokens.ready = cmd_ready;
	assign cmd_valid    = tokens.valid;
	assign accept       = tokens.valid && cmd_ready;

	assign top_idx  = IDX_W'(depth_q - DEPTH_W'(1));
	assign push_idx = IDX_W'(depth_q);
	assign top_arr  = arr_q[top_idx];
	assign top_has  = has_q[top_idx];
	assign top_odd  = odd_q[top_idx];
	assign ind      = (indent > 3'd4) ? 3'd4 : indent;

	// Type of the value that the token opens
	always_comb begin
		case (tokens.func)
			jts_pkg::FN_OPEN_OBJ:  vt = jts_pkg::VT_OBJECT;
			jts_pkg::FN_OPEN_ARR:  vt = jts_pkg::VT_ARRAY;
			jts_pkg::FN_OPEN_STR:  vt = jts_pkg::VT_STRING;
			jts_pkg::FN_BOOL:      vt = jts_pkg::VT_BOOL;
			default:               vt = tokens.value_type;
		endcase
	end

	// Value prefix check: second root, or an object key that is not a string
	always_comb begin
		pre_err = jts_pkg::ERR_OK;
		if (depth_q == '0) begin
			if (root_q) pre_err = jts_pkg::ERR_SECOND_ROOT;
		end else if (!top_arr && !top_odd && vt != jts_pkg::VT_STRING) begin
			pre_err = jts_pkg::ERR_KEY_NOT_STR;
		end
	end

	// Classify the token, build the command and the next stack
	always_comb begin
		logic apply;
		logic push;
		logic pop;
		apply   = 1'b0;
		push    = 1'b0;
		pop     = 1'b0;
		cmd     = '0;
		arr_d   = arr_q;
		has_d   = has_q;
		odd_d   = odd_q;
		depth_d = depth_q;
		root_d  = root_q;

		case (tokens.func)
			jts_pkg::FN_OPEN_OBJ, jts_pkg::FN_OPEN_ARR: begin
				cmd.err = pre_err;
				if (pre_err == jts_pkg::ERR_OK && depth_q >= DEPTH_W'(MAX_DEPTH))
					cmd.err = jts_pkg::ERR_TOO_DEEP;
				if (cmd.err == jts_pkg::ERR_OK) begin
					apply    = 1'b1;
					push     = 1'b1;
					cmd.kind = jts_pkg::BK_CHAR;
					cmd.data = (tokens.func == jts_pkg::FN_OPEN_OBJ) ?
						jts_pkg::CH_LBRACE : jts_pkg::CH_RBRACK - 8'd2;
				end
			end
			jts_pkg::FN_CLOSE_OBJ, jts_pkg::FN_CLOSE_ARR: begin
				if (depth_q == '0)
					cmd.err = jts_pkg::ERR_CLOSE_ROOT;
				else if (top_arr != (tokens.func == jts_pkg::FN_CLOSE_ARR))
					cmd.err = jts_pkg::ERR_KIND;
				else if (tokens.func == jts_pkg::FN_CLOSE_OBJ && top_odd)
					cmd.err = jts_pkg::ERR_KEY_NO_VALUE;
				if (cmd.err == jts_pkg::ERR_OK) begin
					pop      = 1'b1;
					cmd.nl   = pretty;
					cmd.sp   = pretty ? jts_pkg::SP_W'(depth_q - DEPTH_W'(1)) *
						jts_pkg::SP_W'(ind) : '0;
					cmd.kind = jts_pkg::BK_CHAR;
					cmd.data = (tokens.func == jts_pkg::FN_CLOSE_OBJ) ?
						jts_pkg::CH_RBRACE : jts_pkg::CH_RBRACK;
				end
			end
			jts_pkg::FN_OPEN_STR: begin
				cmd.err = pre_err;
				if (pre_err == jts_pkg::ERR_OK) begin
					apply    = 1'b1;
					cmd.kind = jts_pkg::BK_CHAR;
					cmd.data = jts_pkg::CH_QUOTE;
				end
			end
			jts_pkg::FN_STR_BYTE: begin
				cmd.kind = jts_pkg::BK_ESC;
				cmd.data = tokens.in_byte;
			end
			jts_pkg::FN_CLOSE_STR: begin
				cmd.kind = jts_pkg::BK_CHAR;
				cmd.data = jts_pkg::CH_QUOTE;
			end
			jts_pkg::FN_RAW_START: begin
				cmd.err = pre_err;
				if (pre_err == jts_pkg::ERR_OK) apply = 1'b1;
			end
			jts_pkg::FN_RAW_BYTE: begin
				cmd.kind = jts_pkg::BK_CHAR;
				cmd.data = tokens.in_byte;
			end
			jts_pkg::FN_BOOL: begin
				cmd.err = pre_err;
				if (pre_err == jts_pkg::ERR_OK) begin
					apply    = 1'b1;
					cmd.kind = tokens.in_byte[0] ? jts_pkg::BK_TRUE : jts_pkg::BK_FALSE;
				end
			end
			default: begin
				cmd.kind = jts_pkg::BK_NONE;
			end
		endcase

		// Separator, newline and count for a value inside a level
		if (apply) begin
			if (depth_q == '0) begin
				root_d = 1'b1;
			end else begin
				cmd.pre        = top_has;
				cmd.colon      = !top_arr && top_odd;
				cmd.nl         = pretty && (top_arr || !top_odd);
				cmd.sp         = cmd.nl ? jts_pkg::SP_W'(depth_q) * jts_pkg::SP_W'(ind) : '0;
				has_d[top_idx] = 1'b1;
				odd_d[top_idx] = !top_odd;
			end
		end

		if (push) begin
			arr_d[push_idx] = (tokens.func == jts_pkg::FN_OPEN_ARR);
			has_d[push_idx] = 1'b0;
			odd_d[push_idx] = 1'b0;
			depth_d         = depth_q + DEPTH_W'(1);
		end

		if (pop) depth_d = depth_q - DEPTH_W'(1);
	end

	// Nesting stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arr_q   <= '0;
			has_q   <= '0;
			odd_q   <= '0;
			depth_q <= '0;
			root_q  <= 1'b0;
		end else if (accept) begin
			arr_q   <= arr_d;
			has_q   <= has_d;
			odd_q   <= odd_d;
			depth_q <= depth_d;
			root_q  <= root_d;
		end
	end

endmodule

/* hdl/jts_queue.sv */
`timescale 1ns / 1ps

module jts_queue #(
	parameter int DEPTH = jts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  jts_pkg::cmd_t wr_cmd,
	input  logic          wr_valid,
	output logic          wr_ready,
	output jts_pkg::cmd_t rd_cmd,
	output logic          rd_valid,
	input  logic          rd_ready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jts_pkg::cmd_t    slot_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push, pop;

	assign wr_ready = (cnt_q != CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = slot_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Command storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= wr_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			if (pop)  rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			if (push && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

/* hdl/jts_back.sv */
`timescale 1ns / 1ps

module jts_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jts_pkg::cmd_t in_cmd,
	input  logic          in_valid,
	output logic          in_ready,
	jts_out_if.source     chars
);

	localparam logic [2:0] PH_PRE   = 3'd0;
	localparam logic [2:0] PH_NL    = 3'd1;
	localparam logic [2:0] PH_SP    = 3'd2;
	localparam logic [2:0] PH_BODY  = 3'd3;
	localparam logic [2:0] PH_EMPTY = 3'd4;
	localparam logic [2:0] PH_DONE  = 3'd5;

	// Escape letter of a string byte, zero when it goes out as is
	function automatic logic [7:0] esc_char(input logic [7:0] c);
		logic [7:0] e;
		e = 8'h00;
		if (c < 8'h20) begin
			case (c)
				8'h08:   e = 8'h62;
				8'h09:   e = 8'h74;
				8'h0A:   e = 8'h6E;
				8'h0C:   e = 8'h66;
				8'h0D:   e = 8'h72;
				default: e = 8'h75;
			endcase
		end else if (c == jts_pkg::CH_QUOTE) begin
			e = jts_pkg::CH_QUOTE;
		end else if (c == jts_pkg::CH_BSLASH) begin
			e = jts_pkg::CH_BSLASH;
		end
		return e;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
	endfunction

	// Number of body characters
	function automatic logic [2:0] body_len(input logic [2:0] kind, input logic [7:0] d);
		logic [2:0] n;
		case (kind)
			jts_pkg::BK_CHAR:  n = 3'd1;
			jts_pkg::BK_ESC: begin
				if (esc_char(d) == 8'h00)      n = 3'd1;
				else if (esc_char(d) == 8'h75) n = 3'd6;
				else                           n = 3'd2;
			end
			jts_pkg::BK_TRUE:  n = 3'd4;
			jts_pkg::BK_FALSE: n = 3'd5;
			default:           n = 3'd0;
		endcase
		return n;
	endfunction

	// Body character at a position
	function automatic logic [7:0] body_byte(input logic [2:0] kind, input logic [7:0] d,
		input logic [2:0] i);
		logic [7:0] b;
		b = 8'h00;
		case (kind)
			jts_pkg::BK_ESC: begin
				case (i)
					3'd0:    b = (esc_char(d) == 8'h00) ? d : jts_pkg::CH_BSLASH;
					3'd1:    b = esc_char(d);
					3'd4:    b = hex_digit(d[7:4]);
					3'd5:    b = hex_digit(d[3:0]);
					default: b = 8'h30;
				endcase
			end
			jts_pkg::BK_TRUE: begin
				case (i)
					3'd0:    b = 8'h74;
					3'd1:    b = 8'h72;
					3'd2:    b = 8'h75;
					default: b = 8'h65;
				endcase
			end
			jts_pkg::BK_FALSE: begin
				case (i)
					3'd0:    b = 8'h66;
					3'd1:    b = 8'h61;
					3'd2:    b = 8'h6C;
					3'd3:    b = 8'h73;
					default: b = 8'h65;
				endcase
			end
			default: b = d;
		endcase
		return b;
	endfunction

	jts_pkg::cmd_t          cmd_q;
	logic                   busy_q;
	logic [2:0]             ph_q, ph_nxt, ph_first;
	logic [jts_pkg::SP_W-1:0] sp_q;
	logic [2:0]             bi_q;
	logic [2:0]             blen, blen_in;

	logic                   out_valid_q, out_bv_q, out_last_q;
	logic [7:0]             out_byte_q;
	logic [2:0]             out_err_q;

	logic                   out_free, emit, load;
	logic [7:0]             cur_byte;

	assign out_free = !out_valid_q || chars.ready;
	assign emit     = busy_q && out_free;
	assign in_ready = !busy_q;
	assign load     = in_valid && !busy_q;
	assign blen     = body_len(cmd_q.kind, cmd_q.data);
	assign blen_in  = body_len(in_cmd.kind, in_cmd.data);

	// First phase of a freshly loaded command
	always_comb begin
		if (in_cmd.err != jts_pkg::ERR_OK) ph_first = PH_EMPTY;
		else if (in_cmd.pre)               ph_first = PH_PRE;
		else if (in_cmd.nl)                ph_first = PH_NL;
		else if (blen_in != 3'd0)          ph_first = PH_BODY;
		else                               ph_first = PH_EMPTY;
	end

	// Current character and the phase after it
	always_comb begin
		cur_byte = 8'h00;
		ph_nxt   = PH_DONE;
		case (ph_q)
			PH_PRE: begin
				cur_byte = cmd_q.colon ? jts_pkg::CH_COLON : jts_pkg::CH_COMMA;
				if (cmd_q.nl)           ph_nxt = PH_NL;
				else if (blen != 3'd0)  ph_nxt = PH_BODY;
			end
			PH_NL: begin
				cur_byte = jts_pkg::CH_NL;
				if (sp_q != '0)         ph_nxt = PH_SP;
				else if (blen != 3'd0)  ph_nxt = PH_BODY;
			end
			PH_SP: begin
				cur_byte = jts_pkg::CH_SPACE;
				if (sp_q != jts_pkg::SP_W'(1)) ph_nxt = PH_SP;
				else if (blen != 3'd0)         ph_nxt = PH_BODY;
			end
			PH_BODY: begin
				cur_byte = body_byte(cmd_q.kind, cmd_q.data, bi_q);
				if (bi_q != blen - 3'd1) ph_nxt = PH_BODY;
			end
			default: begin
				cur_byte = 8'h00;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= PH_EMPTY;
		end else if (load) begin
			busy_q <= 1'b1;
			ph_q   <= ph_first;
		end else if (emit) begin
			ph_q <= ph_nxt;
			if (ph_nxt == PH_DONE) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= in_cmd;
			sp_q  <= in_cmd.sp;
			bi_q  <= 3'd0;
		end else if (emit) begin
			if (ph_q == PH_SP)   sp_q <= sp_q - jts_pkg::SP_W'(1);
			if (ph_q == PH_BODY) bi_q <= bi_q + 3'd1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (chars.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= cur_byte;
			out_bv_q   <= (ph_q != PH_EMPTY);
			out_last_q <= (ph_nxt == PH_DONE);
			out_err_q  <= (ph_q == PH_EMPTY) ? cmd_q.err : jts_pkg::ERR_OK;
		end
	end

	assign chars.valid      = out_valid_q;
	assign chars.out_byte   = out_byte_q;
	assign chars.byte_valid = out_bv_q;
	assign chars.last       = out_last_q;
	assign chars.error_code = out_err_q;

endmodule

/* hdl/json_token_serializer.sv */
`timescale 1ns / 1ps

// JSON token serializer. Tokens come in on the tokens channel and leave as characters on the
// chars channel, one character per word, with last on the final word of each token; a token
// that breaks a nesting rule, or emits nothing, leaves as one empty word (byte_valid low)
// carrying its error code. The front checks each token against the nesting stack in the
// cycle it is accepted, so it takes one token per cycle while its command queue has room.
// The back loads a queued command and then turns it into characters at one per cycle while
// the output is ready; it takes the next command only after the last character of the one
// before. A control byte in a string may go out as a \u00XX escape.
// Registers: 0x0 pretty_print (bit 0), 0x4 indent_size (bits 2:0, above 4 acts as 4).

module json_token_serializer #(
	parameter int MAX_DEPTH   = jts_pkg::MAX_DEPTH_DEF,
	parameter int QUEUE_DEPTH = jts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	jts_in_if.sink      tokens,
	jts_out_if.source   chars
);

	logic          pretty_q;
	logic [2:0]    indent_q;
	logic          cfg_wr;

	jts_pkg::cmd_t f_cmd, b_cmd;
	logic          f_valid, f_ready, b_valid, b_ready;

	// Config registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pretty_q <= 1'b0;
			indent_q <= 3'd4;
		end else if (cfg_wr) begin
			if (paddr[2] == jts_pkg::REG_PRETTY) pretty_q <= pwdata[0];
			else                                 indent_q <= pwdata[2:0];
		end
	end

	assign prdata = (paddr[2] == jts_pkg::REG_INDENT) ? {29'd0, indent_q} : {31'd0, pretty_q};

	jts_front #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pretty   (pretty_q),
		.indent   (indent_q),
		.tokens   (tokens),
		.cmd      (f_cmd),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready)
	);

	jts_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_cmd  (f_cmd),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.rd_cmd  (b_cmd),
		.rd_valid(b_valid),
		.rd_ready(b_ready)
	);

	jts_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_cmd  (b_cmd),
		.in_valid(b_valid),
		.in_ready(b_ready),
		.chars   (chars)
	);

endmodule
